FILE: rtl/iru_pkg.sv
// Package for the index register unit: item, state, write request and result types,
// command codes and sizing constants.
// No dependencies.
package iru_pkg;

    // Width of each wrap range in integer units
    localparam int RANGE_BITS = 10;
    // Configuration port sizing (four range registers, data as wide as a range)
    localparam int CFG_DATA_W  = RANGE_BITS;
    localparam int CFG_INDEX_W = 2;
    localparam int NUM_IDX     = 4;
    localparam int IDX_W       = 2;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 16;
    localparam int FRAC_W      = 16;

    // Command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_MOVE   = 3'd1;
    localparam logic [2:0] CMD_RANGE  = 3'd2;
    localparam logic [2:0] CMD_MODULO = 3'd3;
    localparam logic [2:0] CMD_LOAD0  = 3'd4;
    localparam logic [2:0] CMD_LOAD1  = 3'd5;

    // One input item
    typedef struct packed {
        logic [2:0]       command;
        logic [IDX_W-1:0] dest_index;
        logic [IDX_W-1:0] src_index;
        logic [VAL_W-1:0] operand_value;
        logic             dec_counter0;
        logic             dec_counter1;
    } item_t;

    // Counters and status flags
    typedef struct packed {
        logic [CNT_W-1:0] cnt0;
        logic [CNT_W-1:0] cnt1;
        logic             c0_zero;
        logic             c1_zero;
        logic             mod_ge;
        logic             mod_mi;
    } state_t;

    // Index register write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } wr_t;

    // One result item: index value plus counters and flags after the step
    typedef struct packed {
        logic [VAL_W-1:0] index_result;
        state_t           st;
    } result_t;

endpackage

FILE: rtl/iru_ram.sv
// Generic register file: one write port, two registered read ports.
// No dependencies.
module iru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered reads, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/iru_core.sv
// Execute datapath of the index register unit: one command, range wrap
// and counter decrements, all combinational.
// Depends on iru_pkg.
module iru_core
    import iru_pkg::*;
(
    input  item_t                 item,
    input  logic [VAL_W-1:0]      dst_value,
    input  logic [VAL_W-1:0]      src_value,
    input  logic [RANGE_BITS-1:0] range_value,
    input  state_t                st,
    output wr_t                   wr,
    output result_t               res
);

    localparam int CMP_W = VAL_W + 1;

    logic [CMP_W-1:0] ip_ext;
    logic [CMP_W-1:0] rng_ext;
    logic [VAL_W-1:0] rng;
    logic             ge;
    logic             mi;
    logic [VAL_W-1:0] wrapped;
    logic [CNT_W-1:0] c0_load;
    logic [CNT_W-1:0] c1_load;

    // Range check: signed integer part against the range, 33-bit compare
    always_comb
    begin
        ip_ext  = {src_value[VAL_W-1], src_value[VAL_W-1:FRAC_W], {FRAC_W{1'b0}}};
        rng_ext = {{(CMP_W-RANGE_BITS-FRAC_W){1'b0}}, range_value, {FRAC_W{1'b0}}};
        rng     = rng_ext[VAL_W-1:0];
        ge      = $signed(ip_ext) >= $signed(rng_ext);
        mi      = !ge && src_value[VAL_W-1];
        if (ge)
        begin
            wrapped = src_value - rng;
        end
        else if (mi)
        begin
            wrapped = src_value + rng;
        end
        else
        begin
            wrapped = src_value;
        end
    end

    // Command decode
    always_comb
    begin
        wr.en            = 1'b0;
        wr.addr          = item.dest_index;
        wr.data          = dst_value + item.operand_value;
        res.index_result = '0;
        res.st           = st;
        c0_load          = st.cnt0;
        c1_load          = st.cnt1;
        case (item.command)
            CMD_ADD:
            begin
                wr.en            = 1'b1;
                res.index_result = wr.data;
            end
            CMD_MOVE:
            begin
                wr.en            = 1'b1;
                wr.data          = item.operand_value;
                res.index_result = item.operand_value;
            end
            CMD_RANGE:
            begin
                res.index_result = wrapped;
                res.st.mod_ge    = ge;
                res.st.mod_mi    = mi;
            end
            CMD_MODULO:
            begin
                wr.en            = 1'b1;
                wr.data          = wrapped;
                res.index_result = wrapped;
                res.st.mod_ge    = ge;
                res.st.mod_mi    = mi;
            end
            CMD_LOAD0:
            begin
                c0_load = item.operand_value[CNT_W-1:0];
            end
            CMD_LOAD1:
            begin
                c1_load = item.operand_value[CNT_W-1:0];
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase

        // Decrements after the command, stopping at zero
        res.st.cnt0 = c0_load;
        res.st.cnt1 = c1_load;
        if (item.dec_counter0)
        begin
            if (c0_load != '0)
            begin
                res.st.cnt0 = c0_load - CNT_W'(1);
            end
            res.st.c0_zero = (res.st.cnt0 == '0);
        end
        if (item.dec_counter1)
        begin
            if (c1_load != '0)
            begin
                res.st.cnt1 = c1_load - CNT_W'(1);
            end
            res.st.c1_zero = (res.st.cnt1 == '0);
        end
    end

endmodule

FILE: rtl/index_register_unit.sv
// Top level of the index register unit: input stage, register file,
// execute datapath and result register.
// Depends on iru_pkg, iru_ram and iru_core.

// Executes one index-unit command per item: four 16.16 index registers with
// programmable wrap ranges, two 16-bit loop counters and four status flags.
// Throughput is one item per clock while the output is not stalled. An
// accepted item is held in the input stage, where its register file reads
// land; it executes in the next cycle that the result register is free,
// updating the index registers, counters and flags in that same cycle, so a
// dependent item may follow immediately. The result is then registered and
// held while the output is stalled. Range registers are written on cfg_we;
// the user must do so only while the unit is idle, which is not enforced.
module index_register_unit
    import iru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             command,
    input  logic [IDX_W-1:0]       dest_index,
    input  logic [IDX_W-1:0]       src_index,
    input  logic signed [VAL_W-1:0] operand_value,
    input  logic                   dec_counter0,
    input  logic                   dec_counter1,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [VAL_W-1:0] index_result,
    output logic [CNT_W-1:0]       counter0_value,
    output logic [CNT_W-1:0]       counter1_value,
    output logic                   counter0_zero,
    output logic                   counter1_zero,
    output logic                   mod_ge,
    output logic                   mod_mi
);

    logic                  in_valid_reg;
    item_t                 item_reg;
    logic                  out_valid_reg;
    result_t               out_reg;
    state_t                st_reg;
    logic [RANGE_BITS-1:0] range_reg [NUM_IDX];
    logic [NUM_IDX-1:0]    written_reg;

    // read-side qualifiers captured with the register file read
    logic                  dst_byp_reg;
    logic                  src_byp_reg;
    logic                  dst_ok_reg;
    logic                  src_ok_reg;
    logic [VAL_W-1:0]      byp_data_reg;

    item_t                 in_item;
    logic                  accept;
    logic                  exec;
    logic                  out_free;
    logic [VAL_W-1:0]      ram_dst;
    logic [VAL_W-1:0]      ram_src;
    logic [VAL_W-1:0]      dst_value;
    logic [VAL_W-1:0]      src_value;
    wr_t                   wr;
    logic                  wr_fire;
    result_t               res;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign exec     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !exec;
    assign accept   = in_valid && !in_stall;
    assign wr_fire  = exec && wr.en;

    assign in_item.command       = command;
    assign in_item.dest_index    = dest_index;
    assign in_item.src_index     = src_index;
    assign in_item.operand_value = operand_value;
    assign in_item.dec_counter0  = dec_counter0;
    assign in_item.dec_counter1  = dec_counter1;

    // Index register file
    iru_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_IDX)
    ) u_regfile (
        .clk       (clk),
        .we        (wr_fire),
        .wr_addr   (wr.addr),
        .wr_data   (wr.data),
        .rd_en     (accept),
        .rd_addr_a (dest_index),
        .rd_addr_b (src_index),
        .rd_data_a (ram_dst),
        .rd_data_b (ram_src)
    );

    // Operand select: forwarded write, stored value, or reset zero
    assign dst_value = dst_byp_reg ? byp_data_reg : (dst_ok_reg ? ram_dst : '0);
    assign src_value = src_byp_reg ? byp_data_reg : (src_ok_reg ? ram_src : '0);

    iru_core u_core (
        .item        (item_reg),
        .dst_value   (dst_value),
        .src_value   (src_value),
        .range_value (range_reg[item_reg.src_index]),
        .st          (st_reg),
        .wr          (wr),
        .res         (res)
    );

    // Control state, counters, flags and ranges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            written_reg   <= '0;
            for (int i = 0; i < NUM_IDX; i++)
            begin
                range_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                in_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= res.st;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_fire)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (cfg_we)
            begin
                range_reg[cfg_index] <= RANGE_BITS'(cfg_data);
            end
        end
    end

    // Payload: input stage, forwarding qualifiers, result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= in_item;
            dst_byp_reg  <= wr_fire && (wr.addr == dest_index);
            src_byp_reg  <= wr_fire && (wr.addr == src_index);
            dst_ok_reg   <= written_reg[dest_index];
            src_ok_reg   <= written_reg[src_index];
            byp_data_reg <= wr.data;
        end
        if (exec)
        begin
            out_reg <= res;
        end
    end

    // Outputs
    assign out_valid      = out_valid_reg;
    assign index_result   = out_reg.index_result;
    assign counter0_value = out_reg.st.cnt0;
    assign counter1_value = out_reg.st.cnt1;
    assign counter0_zero  = out_reg.st.c0_zero;
    assign counter1_zero  = out_reg.st.c1_zero;
    assign mod_ge         = out_reg.st.mod_ge;
    assign mod_mi         = out_reg.st.mod_mi;

`ifndef SYNTHESIS
    // A range check never reports both outcomes
    a_ge_mi_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_reg.mod_ge && st_reg.mod_mi))
        else $error("mod_ge and mod_mi both set");

    // After a decrement, the zero flag tracks the counter
    a_c0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        exec && item_reg.dec_counter0 |=> st_reg.c0_zero == (st_reg.cnt0 == '0))
        else $error("counter0 zero flag mismatch");

    // An executed item always produces a pending result
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed item lost its result");
`endif

endmodule
